// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL of the mixed fraction ALU top level.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ----- design/mfa_pkg.sv -----
// Package for the mixed fraction ALU: word widths, operation and status codes,
// sign extension helper. No dependencies.
package mfa_pkg;
  localparam int WORD_BITS = 32;
  localparam int WIDE      = 4 * WORD_BITS;
  localparam int MPL_BITS  = 2 * WORD_BITS;
  localparam int DCNT_BITS = $clog2(WIDE + 1);
  localparam int GK_BITS   = $clog2(WIDE);

  typedef logic [WIDE-1:0] wide_t;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_CMP = 3'd4;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_DIV0 = 2'd1;
  localparam logic [1:0] STAT_OVF  = 2'd2;

  function automatic wide_t sext(input logic [31:0] x);
    sext = {{(WIDE-WORD_BITS){x[WORD_BITS-1]}}, x[WORD_BITS-1:0]};
  endfunction
endpackage

// ----- design/mixed_fraction_alu.sv -----
// Mixed fraction ALU top level: sequencer around one shift-add multiplier,
// one restoring divider step and a binary GCD step. Depends on mfa_pkg and
// assert_macros.svh.
//
// Usage: an item is one transfer on the s_axis group: operation in tuser,
// the two mixed numbers (whole, num, den each) in tdata. One result goes
// out as one transfer on m_axis: whole, num, den in tdata; compare flags
// and status in tuser.
// Each operand is flattened with a shift-add multiply, then up to three
// multiplies form the numerator and denominator. The exact quotient comes
// from a division, the remainder and denominator are reduced by a binary
// GCD (one shift or subtract per cycle) and two divisions. Compare skips
// the division and GCD; arithmetic runs on the shared multiplier, divider
// and GCD loop. s_axis_tready is high only while idle. A finished result
// waits in the output register; if the receiver stalls, the next item is
// taken but its result holds until the output frees. Reset returns the
// sequencer to idle and drops m_axis_tvalid.
module mixed_fraction_alu (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_whole, a_num, a_den, b_whole, b_num, b_den (32 each, low bits first)
  input  logic [191:0] s_axis_tdata,
  // operation
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // result_whole, result_num, result_den (32 each, low bits first)
  output logic [95:0]  m_axis_tdata,
  // is_less, is_greater, is_identical, status[1:0]
  output logic [4:0]   m_axis_tuser
);
  import mfa_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_GZ   = 4'd4;
  localparam logic [3:0] S_GSH  = 4'd5;
  localparam logic [3:0] S_GU   = 4'd6;
  localparam logic [3:0] S_GL   = 4'd7;
  localparam logic [3:0] S_GK   = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;

  localparam logic [3:0] P_FLAT_A = 4'd0;
  localparam logic [3:0] P_FLAT_B = 4'd1;
  localparam logic [3:0] P_MUL1   = 4'd2;
  localparam logic [3:0] P_MUL2   = 4'd3;
  localparam logic [3:0] P_MUL3   = 4'd4;
  localparam logic [3:0] P_DIVN   = 4'd5;
  localparam logic [3:0] P_GCD    = 4'd6;
  localparam logic [3:0] P_DIVD   = 4'd7;
  localparam logic [3:0] P_DIVR   = 4'd8;

  localparam wide_t HALF = wide_t'(1) << (WORD_BITS - 1);

  logic [3:0]          state;
  logic [3:0]          phase;
  logic [2:0]          op;
  logic [31:0]         wa, na, wb, nb, ad, bd;
  wide_t               av, bv, t1;
  wide_t               acc, mcand;
  logic [MPL_BITS-1:0] mplier;
  logic                nneg;
  wide_t               nmag, dden, qv;
  wide_t               dq_sh, drem, ddiv;
  logic [DCNT_BITS-1:0] dcnt;
  wide_t               gu, gv;
  logic [GK_BITS-1:0]  gk;
  logic [31:0]         res_whole, res_num, res_den;
  logic [2:0]          res_flags;
  logic [1:0]          res_stat;

  logic                ad_zero, bd_zero;
  wide_t               ad_w, bd_w;
  wide_t               bv_new, av_neg, bv_new_abs, bv_abs, n_sum, n_abs;
  logic [WIDE:0]       trial, trial_sub, gdiff;
  wide_t               gu_nz;
  logic                ovf;
  logic [31:0]         q32, r32;

  assign ad_w  = wide_t'(ad[WORD_BITS-1:0]);
  assign bd_w  = wide_t'(bd[WORD_BITS-1:0]);
  assign ad_zero = (ad_w == '0);
  assign bd_zero = (bd_w == '0);
  assign bv_new = acc + sext(nb);
  assign av_neg = '0 - av;
  assign bv_new_abs = bv_new[WIDE-1] ? ('0 - bv_new) : bv_new;
  assign bv_abs = bv[WIDE-1] ? ('0 - bv) : bv;
  assign n_sum  = (op == OP_SUB) ? (t1 - acc) : (t1 + acc);
  assign n_abs  = n_sum[WIDE-1] ? ('0 - n_sum) : n_sum;
  assign trial  = {drem, dq_sh[WIDE-1]};
  assign trial_sub = trial - {1'b0, ddiv};
  assign gdiff  = {1'b0, gv} - {1'b0, gu};
  assign gu_nz  = gu;

  // overflow: reduced denominator above one word, whole or remainder out of range
  always_comb begin
    ovf = (dden[WIDE-1:WORD_BITS] != '0)
       || (qv > (nneg ? HALF : HALF - wide_t'(1)))
       || (dq_sh > HALF - wide_t'(1));
  end
  assign q32 = 32'(qv[WORD_BITS-1:0]);
  assign r32 = 32'(dq_sh[WORD_BITS-1:0]);

  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= P_FLAT_A;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) m_axis_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op <= s_axis_tuser;
            wa <= s_axis_tdata[31:0];
            na <= s_axis_tdata[63:32];
            ad <= s_axis_tdata[95:64];
            wb <= s_axis_tdata[127:96];
            nb <= s_axis_tdata[159:128];
            bd <= s_axis_tdata[191:160];
            acc    <= '0;
            mcand  <= sext(s_axis_tdata[31:0]);
            mplier <= MPL_BITS'(s_axis_tdata[WORD_BITS+63:64]);
            phase  <= P_FLAT_A;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          if (mplier == '0) begin
            state <= S_DISP;
          end else begin
            if (mplier[0]) acc <= acc + mcand;
            mcand  <= mcand << 1;
            mplier <= mplier >> 1;
          end
        end
        S_DISP: begin
          case (phase)
            P_FLAT_A: begin
              // neutral result until a later phase fills it in
              res_whole <= '0;
              res_num   <= '0;
              res_den   <= 32'd1;
              res_flags <= '0;
              res_stat  <= STAT_OK;
              av     <= acc + sext(na);
              acc    <= '0;
              mcand  <= sext(wb);
              mplier <= MPL_BITS'(bd[WORD_BITS-1:0]);
              phase  <= P_FLAT_B;
              state  <= S_MUL;
            end
            P_FLAT_B: begin
              bv <= bv_new;
              if (op > OP_CMP) begin
                state <= S_FIN;
              end else if (op != OP_CMP && (ad_zero || bd_zero)) begin
                res_stat <= STAT_DIV0;
                state <= S_FIN;
              end else if (op == OP_DIV && bv_new == '0) begin
                res_stat <= STAT_DIV0;
                state <= S_FIN;
              end else begin
                acc   <= '0;
                mcand <= ((op == OP_MUL || op == OP_DIV) && bv_new[WIDE-1]) ? av_neg : av;
                mplier <= (op == OP_MUL) ? bv_new_abs[MPL_BITS-1:0] : MPL_BITS'(bd_w);
                phase <= P_MUL1;
                state <= S_MUL;
              end
            end
            P_MUL1: begin
              t1     <= acc;
              acc    <= '0;
              mcand  <= bv;
              mplier <= (op == OP_MUL || op == OP_DIV) ? '0 : MPL_BITS'(ad_w);
              phase  <= P_MUL2;
              state  <= S_MUL;
            end
            P_MUL2: begin
              if (op == OP_CMP) begin
                res_flags <= {(wa[WORD_BITS-1:0] == wb[WORD_BITS-1:0])
                                && (na[WORD_BITS-1:0] == nb[WORD_BITS-1:0])
                                && (ad_w == bd_w),
                              $signed(t1) > $signed(acc),
                              $signed(t1) < $signed(acc)};
                state <= S_FIN;
              end else begin
                nneg   <= n_sum[WIDE-1];
                nmag   <= n_abs;
                acc    <= '0;
                mcand  <= ad_w;
                mplier <= (op == OP_DIV) ? bv_abs[MPL_BITS-1:0] : MPL_BITS'(bd_w);
                phase  <= P_MUL3;
                state  <= S_MUL;
              end
            end
            P_MUL3: begin
              dden  <= acc;
              ddiv  <= acc;
              dq_sh <= nmag;
              drem  <= '0;
              dcnt  <= DCNT_BITS'(WIDE);
              phase <= P_DIVN;
              state <= S_DIV;
            end
            P_DIVN: begin
              // q, r of N / D; gcd(N, D) equals gcd(r, D)
              qv    <= dq_sh;
              nmag  <= drem;
              gu    <= drem;
              gv    <= dden;
              gk    <= '0;
              phase <= P_GCD;
              state <= S_GZ;
            end
            P_GCD: begin
              ddiv  <= gu;
              dq_sh <= dden << WORD_BITS;
              drem  <= '0;
              dcnt  <= DCNT_BITS'(3 * WORD_BITS);
              phase <= P_DIVD;
              state <= S_DIV;
            end
            P_DIVD: begin
              dden  <= dq_sh;
              dq_sh <= nmag << WORD_BITS;
              drem  <= '0;
              dcnt  <= DCNT_BITS'(3 * WORD_BITS);
              phase <= P_DIVR;
              state <= S_DIV;
            end
            P_DIVR: begin
              if (ovf) begin
                res_stat <= STAT_OVF;
              end else begin
                res_whole <= nneg ? (32'd0 - q32) : q32;
                res_num   <= nneg ? (32'd0 - r32) : r32;
                res_den   <= 32'(dden[WORD_BITS-1:0]);
              end
              state <= S_FIN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_DIV: begin
          if (dcnt == '0) begin
            state <= S_DISP;
          end else begin
            if (!trial_sub[WIDE]) begin
              drem  <= trial_sub[WIDE-1:0];
              dq_sh <= {dq_sh[WIDE-2:0], 1'b1};
            end else begin
              drem  <= trial[WIDE-1:0];
              dq_sh <= {dq_sh[WIDE-2:0], 1'b0};
            end
            dcnt <= dcnt - 1'b1;
          end
        end
        S_GZ: begin
          if (gu_nz == '0) begin
            gu    <= gv;
            state <= S_DISP;
          end else begin
            state <= S_GSH;
          end
        end
        S_GSH: begin
          if (gu[0] || gv[0]) begin
            state <= S_GU;
          end else begin
            gu <= gu >> 1;
            gv <= gv >> 1;
            gk <= gk + 1'b1;
          end
        end
        S_GU: begin
          if (gu[0]) state <= S_GL;
          else gu <= gu >> 1;
        end
        S_GL: begin
          if (gv == '0) begin
            state <= S_GK;
          end else if (!gv[0]) begin
            gv <= gv >> 1;
          end else if (gdiff[WIDE]) begin
            // u above v: swap, then subtract
            gu <= gv;
            gv <= gu - gv;
          end else begin
            gv <= gdiff[WIDE-1:0];
          end
        end
        S_GK: begin
          gu    <= gu << gk;
          state <= S_DISP;
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {res_den, res_num, res_whole};
            m_axis_tuser  <= {res_stat, res_flags};
            m_axis_tvalid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"
  `ASSERT_AT(a_den_nonzero, clk, rst, m_axis_tvalid |-> m_axis_tdata[95:64] != 32'd0, "zero denominator out")
  `ASSERT_AT(a_err_neutral, clk, rst, (m_axis_tvalid && m_axis_tuser[4:3] != STAT_OK) |-> (m_axis_tdata == {32'd1, 64'd0}), "error result not neutral")
  `ASSERT_NEVER(a_flags_excl, clk, rst, m_axis_tvalid && m_axis_tuser[0] && m_axis_tuser[1], "less and greater both set")
  `ASSERT_AT(a_busy_after_take, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "ready right after accept")
endmodule
